/* sv/led_status_animator_unit_defines.svh */
// Assertion macros shared by the status LED animator RTL.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef LED_STATUS_ANIMATOR_UNIT_DEFINES_SVH
`define LED_STATUS_ANIMATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define LSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/lsa_pkg.sv */
// Package for the status LED animator: codes, shared types, pattern functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lsa_pkg;

  localparam int TICK_BITS = 32;
  localparam int NUM_FLASH = 5;

  typedef logic [TICK_BITS-1:0] tick_t;

  // item kinds carried on tuser
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_FLASH = 2'd1;
  localparam logic [1:0] FUNC_BASE  = 2'd2;

  // base states and flash events share one code space
  localparam logic [3:0] BASE_BOOT   = 4'd0;
  localparam logic [3:0] BASE_LINK   = 4'd1;
  localparam logic [3:0] BASE_IDLE   = 4'd2;
  localparam logic [3:0] BASE_STRESS = 4'd3;
  localparam logic [3:0] EV_HTTP     = 4'd4;
  localparam logic [3:0] EV_INFER    = 4'd5;
  localparam logic [3:0] EV_PEER     = 4'd6;
  localparam logic [3:0] EV_HB_TX    = 4'd7;
  localparam logic [3:0] EV_HB_FAIL  = 4'd8;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_BRIGHTNESS = 3'd0;
  localparam logic [2:0] REG_INTERVAL   = 3'd1;
  localparam logic [2:0] REG_T_HTTP     = 3'd2;
  localparam logic [2:0] REG_T_INFER    = 3'd3;
  localparam logic [2:0] REG_T_PEER     = 3'd4;
  localparam logic [2:0] REG_T_HB_TX    = 3'd5;
  localparam logic [2:0] REG_T_HB_FAIL  = 3'd6;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [7:0]                     brightness;
    logic [7:0]                     check_interval;
    logic [NUM_FLASH-1:0][6:0]      flash_len;
  } cfg_t;

  // v % 10 for 7-bit v, via reciprocal 205/2048
  function automatic logic [3:0] mod10(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  q;
    logic [7:0]  qx10;
    p    = 15'(v) * 15'd205;
    q    = p[14:11];
    qx10 = 8'(q) * 8'd10;
    return 4'(8'(v) - qx10);
  endfunction

  // unscaled colour of a pattern; m60/m80 are the phase modulo 60/80,
  // p10 the phase modulo 10
  function automatic rgb_t paint(input logic [3:0] sel, input logic [5:0] m60,
                                 input logic [6:0] m80, input logic [3:0] p10);
    logic [10:0] t17;
    logic [12:0] t45;
    logic [13:0] q10p;
    logic [15:0] b6;
    logic [7:0]  v;
    rgb_t        c;
    c    = '0;
    t17  = (m60 < 6'd30) ? 11'(m60) * 11'd17 : 11'(6'd60 - m60) * 11'd17;
    t45  = (m80 < 7'd40) ? 13'(m80) * 13'd45 : 13'(7'd80 - m80) * 13'd45;
    q10p = 14'(m80) * 14'd205;
    v    = 8'd30 + t45[10:3];
    b6   = 16'(v) * 16'd171;
    case (sel)
      BASE_BOOT: begin
        c.red   = t17[8:1];
        c.green = t17[8:1];
        c.blue  = t17[8:1];
      end
      BASE_LINK: begin
        // on while floor(t/10) is even
        if (!q10p[11]) c.blue = 8'd255;
      end
      BASE_IDLE: begin
        c.green = v;
        c.blue  = {2'b00, b6[15:10]};
      end
      BASE_STRESS: begin
        c.red   = 8'd255;
        c.green = 8'd80;
      end
      EV_HTTP: begin
        c.red   = 8'd255;
        c.green = 8'd255;
        c.blue  = 8'd255;
      end
      EV_INFER: begin
        c.red  = 8'd180;
        c.blue = 8'd255;
      end
      EV_PEER: begin
        if (p10 < 4'd2 || (p10 >= 4'd4 && p10 < 4'd6)) begin
          c.green = 8'd255;
          c.blue  = 8'd255;
        end
      end
      EV_HB_TX: begin
        c.blue = 8'd200;
      end
      EV_HB_FAIL: begin
        c.red = 8'd255;
      end
      default: begin
        c = '0;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* sv/led_status_animator_unit.sv */
// Status LED animator, top level: register port, animator core, scaling stage.
// Depends on lsa_pkg, lsa_core and lsa_scale.
//
// Use:
//  - Input stream (in_*): one beat per item. in_tuser carries the kind:
//    tick, flash request or base-state write. Only a tick produces a result.
//    Flash requests are latched; the next tick takes the latest unless outranked.
//  - Result stream (out_*): one RGB beat per tick, scaled by brightness.
//  - Register port (cfg_*): APB-style, seven registers at byte addresses
//    0x00..0x18, pready tied high. Write only while the block is idle.
//  - Path: a tick beat is registered as its colour in the colour register,
//    then scaled into the output register, which presents its result beat.
//  - Throughput: one beat per cycle unless out_tready stalls the two-stage
//    pipe; the core takes every item kind at the same rate.
//  - Stall: if out_tready is low the output register holds its beat, the
//    colour register behind it fills, and in_tready then drops for every
//    item kind; nothing is dropped or repeated.
//  - Reset (rst_n low, synchronous): state to boot pattern, counters to zero,
//    registers to their defaults, both pipeline stages empty.
`timescale 1ns / 1ps
`default_nettype none

module led_status_animator_unit (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [3:0] event_code, [7:4] base_value, [8] ip_present, [15:9] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  // in_tuser: [1:0] func
  input  logic [1:0]  in_tuser,
  // out_tdata: [7:0] red, [15:8] green, [23:16] blue
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lsa_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       wr_en;
  logic [2:0] reg_idx;
  logic       col_valid, col_ready;
  rgb_t       col, res;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[4:2];

  // register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_BRIGHTNESS: cfg_nxt.brightness     = cfg_pwdata[7:0];
        REG_INTERVAL:   cfg_nxt.check_interval = cfg_pwdata[7:0];
        REG_T_HTTP:     cfg_nxt.flash_len[0]   = cfg_pwdata[6:0];
        REG_T_INFER:    cfg_nxt.flash_len[1]   = cfg_pwdata[6:0];
        REG_T_PEER:     cfg_nxt.flash_len[2]   = cfg_pwdata[6:0];
        REG_T_HB_TX:    cfg_nxt.flash_len[3]   = cfg_pwdata[6:0];
        REG_T_HB_FAIL:  cfg_nxt.flash_len[4]   = cfg_pwdata[6:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_idx)
      REG_BRIGHTNESS: cfg_prdata = 32'(cfg_r.brightness);
      REG_INTERVAL:   cfg_prdata = 32'(cfg_r.check_interval);
      REG_T_HTTP:     cfg_prdata = 32'(cfg_r.flash_len[0]);
      REG_T_INFER:    cfg_prdata = 32'(cfg_r.flash_len[1]);
      REG_T_PEER:     cfg_prdata = 32'(cfg_r.flash_len[2]);
      REG_T_HB_TX:    cfg_prdata = 32'(cfg_r.flash_len[3]);
      REG_T_HB_FAIL:  cfg_prdata = 32'(cfg_r.flash_len[4]);
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.brightness     <= 8'd40;
      cfg_r.check_interval <= 8'd40;
      cfg_r.flash_len[0]   <= 7'd2;
      cfg_r.flash_len[1]   <= 7'd4;
      cfg_r.flash_len[2]   <= 7'd10;
      cfg_r.flash_len[3]   <= 7'd1;
      cfg_r.flash_len[4]   <= 7'd6;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lsa_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .func       (in_tuser),
    .event_code (in_tdata[3:0]),
    .base_value (in_tdata[7:4]),
    .ip_present (in_tdata[8]),
    .col_valid  (col_valid),
    .col        (col),
    .col_ready  (col_ready)
  );

  lsa_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .brightness (cfg_r.brightness),
    .col_valid  (col_valid),
    .col_ready  (col_ready),
    .col        (col),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  assign out_tdata = {res.blue, res.green, res.red};

endmodule

`default_nettype wire

/* sv/lsa_core.sv */
// Animator state and pattern selection; registers the unscaled colour per tick.
// Depends on lsa_pkg and led_status_animator_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "led_status_animator_unit_defines.svh"

module lsa_core (
  input  logic          clk,
  input  logic          rst_n,
  input  lsa_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    func,
  input  logic [3:0]    event_code,
  input  logic [3:0]    base_value,
  input  logic          ip_present,
  output logic          col_valid,
  output lsa_pkg::rgb_t col,
  input  logic          col_ready
);
  import lsa_pkg::*;

  tick_t      tick_r, tick_nxt, last_r, last_nxt, elapsed, tc;
  logic       first_r, first_nxt, had_r, had_nxt;
  logic [3:0] base_r, base_nxt, base_t;
  logic       pend_v_r, pend_v_nxt;
  logic [3:0] pend_c_r, pend_c_nxt;
  logic [3:0] fcode_r, fcode_nxt, fc;
  logic [6:0] fleft_r, fleft_nxt, fl;
  logic [6:0] fphase_r, fphase_nxt, fp;
  logic [5:0] m60_r, m60_nxt, m60c;
  logic [6:0] m80_r, m80_nxt, m80c;
  logic       cvalid_r, cvalid_nxt;
  rgb_t       col_r, col_nxt, colour;

  logic       accept, tick_acc, take, interval_hit, do_check, chk_run, clr, flash_on;
  logic [2:0] len_idx;
  logic [3:0] sel, p10;

  assign in_ready  = !cvalid_r || col_ready;
  assign accept    = in_valid && in_ready;
  assign tick_acc  = accept && (func == FUNC_TICK);
  assign col_valid = cvalid_r;
  assign col       = col_r;

  // flash take-up
  assign take    = pend_v_r && pend_c_r >= EV_HTTP && pend_c_r <= EV_HB_FAIL &&
                   (fleft_r == '0 || pend_c_r >= fcode_r);
  assign len_idx = 3'(pend_c_r - EV_HTTP);
  assign fc      = take ? pend_c_r : fcode_r;
  assign fl      = take ? cfg.flash_len[len_idx] : fleft_r;
  assign fp      = take ? '0 : fphase_r;

  // address check
  assign elapsed      = tick_r - last_r;
  assign interval_hit = elapsed >= tick_t'(cfg.check_interval);
  assign do_check     = !first_r || interval_hit;
  assign chk_run      = do_check && (base_r != BASE_STRESS);
  assign clr          = chk_run && ip_present && !had_r;
  assign base_t       = chk_run ? (ip_present ? BASE_IDLE : BASE_LINK) : base_r;
  assign tc           = clr ? '0 : tick_r;
  assign m60c         = clr ? '0 : m60_r;
  assign m80c         = clr ? '0 : m80_r;

  // render
  assign flash_on = fl != '0;
  assign sel      = flash_on ? fc : base_t;
  assign p10      = flash_on ? mod10(fp) : mod10(m80c);
  assign colour   = paint(sel, m60c, m80c, p10);

  always_comb begin
    tick_nxt   = tick_r;
    last_nxt   = last_r;
    first_nxt  = first_r;
    had_nxt    = had_r;
    base_nxt   = base_r;
    pend_v_nxt = pend_v_r;
    pend_c_nxt = pend_c_r;
    fcode_nxt  = fcode_r;
    fleft_nxt  = fleft_r;
    fphase_nxt = fphase_r;
    m60_nxt    = m60_r;
    m80_nxt    = m80_r;
    cvalid_nxt = cvalid_r;
    col_nxt    = col_r;
    if (in_ready) begin
      cvalid_nxt = tick_acc;
      col_nxt    = colour;
    end
    if (accept) begin
      case (func)
        FUNC_FLASH: begin
          pend_c_nxt = event_code;
          pend_v_nxt = 1'b1;
        end
        FUNC_BASE: begin
          base_nxt = base_value;
        end
        FUNC_TICK: begin
          pend_v_nxt = 1'b0;
          first_nxt  = 1'b1;
          if (first_r && interval_hit) last_nxt = tick_r;
          if (chk_run) had_nxt = ip_present;
          base_nxt   = base_t;
          fcode_nxt  = fc;
          if (flash_on) begin
            fphase_nxt = fp + 7'd1;
            fleft_nxt  = fl - 7'd1;
          end else begin
            fphase_nxt = fp;
            fleft_nxt  = fl;
          end
          tick_nxt = tc + tick_t'(1);
          // phase counters follow tick_count, including its wrap to zero
          if (&tc) begin
            m60_nxt = '0;
            m80_nxt = '0;
          end else begin
            m60_nxt = (m60c == 6'd59) ? '0 : m60c + 6'd1;
            m80_nxt = (m80c == 7'd79) ? '0 : m80c + 7'd1;
          end
        end
        default: begin
          pend_v_nxt = pend_v_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r   <= '0;
      last_r   <= '0;
      first_r  <= 1'b0;
      had_r    <= 1'b0;
      base_r   <= BASE_BOOT;
      pend_v_r <= 1'b0;
      pend_c_r <= '0;
      fcode_r  <= '0;
      fleft_r  <= '0;
      fphase_r <= '0;
      m60_r    <= '0;
      m80_r    <= '0;
      cvalid_r <= 1'b0;
    end else begin
      tick_r   <= tick_nxt;
      last_r   <= last_nxt;
      first_r  <= first_nxt;
      had_r    <= had_nxt;
      base_r   <= base_nxt;
      pend_v_r <= pend_v_nxt;
      pend_c_r <= pend_c_nxt;
      fcode_r  <= fcode_nxt;
      fleft_r  <= fleft_nxt;
      fphase_r <= fphase_nxt;
      m60_r    <= m60_nxt;
      m80_r    <= m80_nxt;
      cvalid_r <= cvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r <= col_nxt;
  end

  `LSA_ASSERT_NEXT(a_tick_gives_colour, tick_acc, cvalid_r, "tick beat lost its colour")
  `LSA_ASSERT_NEXT(a_pending_cleared, tick_acc, !pend_v_r, "pending flash survived a tick")
  `LSA_ASSERT_NEXT(a_stress_kept, tick_acc && base_r == BASE_STRESS, base_r == BASE_STRESS, "check overrode stress")
  `LSA_ASSERT_NOW(a_first_sticky, first_r, first_nxt, "first-check flag fell")

endmodule

`default_nettype wire

/* sv/lsa_scale.sv */
// Brightness scaling stage: colour * brightness / 255, into the output register.
// Depends on lsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsa_scale (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    brightness,
  input  logic          col_valid,
  output logic          col_ready,
  input  lsa_pkg::rgb_t col,
  output logic          res_valid,
  input  logic          res_ready,
  output lsa_pkg::rgb_t res
);
  import lsa_pkg::*;

  logic rvalid_r, rvalid_nxt;
  rgb_t res_r, res_nxt;

  // x/255 for x <= 255*255: (x + (x >> 8) + 1) >> 8
  function automatic logic [7:0] scale8(input logic [7:0] c, input logic [7:0] b);
    logic [15:0] prod;
    logic [16:0] sum;
    prod = 16'(c) * 16'(b);
    sum  = 17'(prod) + 17'(prod[15:8]) + 17'd1;
    return sum[15:8];
  endfunction

  assign col_ready = !rvalid_r || res_ready;
  assign res_valid = rvalid_r;
  assign res       = res_r;

  always_comb begin
    rvalid_nxt = rvalid_r;
    res_nxt    = res_r;
    if (col_ready) begin
      rvalid_nxt    = col_valid;
      res_nxt.red   = scale8(col.red, brightness);
      res_nxt.green = scale8(col.green, brightness);
      res_nxt.blue  = scale8(col.blue, brightness);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvalid_r <= 1'b0;
    end else begin
      rvalid_r <= rvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

`default_nettype wire
